### hw/rtl/lavm_pkg.sv
// Package for the look-at view matrix block: the component, vector and control types and the width and row count.
// It depends on nothing. The normalize unit and the top level import it.
package lavm_pkg;
	localparam int unsigned CompW = 32;
	localparam int unsigned RowCount = 4;

	typedef logic signed [CompW-1:0] comp_t;

	typedef struct packed {
		comp_t x;
		comp_t y;
		comp_t z;
	} vec3_t;

	typedef struct packed {
		logic degen;
		logic valid;
	} ctl_t;
endpackage

### hw/rtl/lavm_norm.sv
// The vector normalize unit of the look-at view matrix block.
// It depends on lavm_pkg. It scales the vector, takes the square root one bit a stage and
// divides by the length one bit a stage, all pipelined.
module lavm_norm #(
	parameter int FRAC_BITS = 16,
	parameter int IN_W = 64
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic signed [IN_W-1:0] in_x,
	input logic signed [IN_W-1:0] in_y,
	input logic signed [IN_W-1:0] in_z,
	output logic out_valid,
	output lavm_pkg::vec3_t out_vec,
	output logic out_zero
);
	import lavm_pkg::*;

	localparam int MW = IN_W;
	localparam int SW = 6 + $clog2(MW);
	localparam int QB = FRAC_BITS + 2;
	localparam int SQ = 34;

	typedef struct packed {
		logic [32:0] mx;
		logic [32:0] my;
		logic [32:0] mz;
		logic nx;
		logic ny;
		logic nz;
		logic zero;
	} nrm_t;

	logic [MW-1:0] ax, ay, az, mxv;
	logic [SW-1:0] lz;
	logic [MW-1:0] sx, sy, sz;
	logic lz_found;

	always_comb begin
		ax = in_x[MW-1] ? MW'(-in_x) : MW'(in_x);
		ay = in_y[MW-1] ? MW'(-in_y) : MW'(in_y);
		az = in_z[MW-1] ? MW'(-in_z) : MW'(in_z);
		mxv = ax;
		if (ay > mxv) begin
			mxv = ay;
		end
		if (az > mxv) begin
			mxv = az;
		end
	end

	// Stage 1: magnitudes and signs registered.
	logic [MW-1:0] ax_s1, ay_s1, az_s1, mx_s1;
	logic nx_s1, ny_s1, nz_s1, v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1 <= ax;
		ay_s1 <= ay;
		az_s1 <= az;
		mx_s1 <= mxv;
		nx_s1 <= in_x[MW-1];
		ny_s1 <= in_y[MW-1];
		nz_s1 <= in_z[MW-1];
	end

	// Position of the leading one of the largest magnitude.
	always_comb begin
		lz = '0;
		lz_found = 1'b0;
		for (int i = MW - 1; i >= 0; i--) begin
			if (!lz_found && mx_s1[i]) begin
				lz = SW'(i);
				lz_found = 1'b1;
			end
		end
	end

	// Stage 2: shift so the largest lies in [2^30, 2^31]. A largest of exactly
	// 2^31 stays; above it right shifts truncate; below 2^30 left shifts.
	logic [SW-1:0] shr, shl;
	logic is_p31;
	always_comb begin
		is_p31 = (mx_s1 == (MW'(1) << 31));
		shr = '0;
		shl = '0;
		if (lz >= SW'(31) && !is_p31) begin
			// Shift right until mx <= 2^31: top bit at 30, or at 31 if exact.
			shr = lz - SW'(30);
			if (((mx_s1 >> (shr - SW'(1))) == (MW'(1) << 31)) && shr != '0) begin
				shr = shr - SW'(1);
			end
		end else if (lz < SW'(30)) begin
			shl = SW'(30) - lz;
		end
		sx = (ax_s1 >> shr) << shl;
		sy = (ay_s1 >> shr) << shl;
		sz = (az_s1 >> shr) << shl;
	end

	nrm_t n_s2;
	logic v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		n_s2.mx <= sx[32:0];
		n_s2.my <= sy[32:0];
		n_s2.mz <= sz[32:0];
		n_s2.nx <= nx_s1;
		n_s2.ny <= ny_s1;
		n_s2.nz <= nz_s1;
		n_s2.zero <= (mx_s1 == '0);
	end

	// Stage 3: squares, one multiplier each.
	logic [65:0] qx_s3, qy_s3, qz_s3;
	nrm_t n_s3;
	logic v_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		qx_s3 <= 66'(n_s2.mx * n_s2.mx);
		qy_s3 <= 66'(n_s2.my * n_s2.my);
		qz_s3 <= 66'(n_s2.mz * n_s2.mz);
		n_s3 <= n_s2;
	end

	// Square root, one result bit per stage, restoring form.
	localparam int RW = 68;
	logic [RW-1:0] rem_p [SQ+1];
	logic [SQ-1:0] root_p [SQ+1];
	logic [RW-1:0] rad_p [SQ+1];
	nrm_t n_p [SQ+1];
	logic v_p [SQ+1];

	always_comb begin
		rad_p[0] = RW'(qx_s3) + RW'(qy_s3) + RW'(qz_s3);
		rem_p[0] = '0;
		root_p[0] = '0;
		n_p[0] = n_s3;
		v_p[0] = v_s3;
	end

	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		logic [RW-1:0] trial, rem_n;
		logic take;
		always_comb begin
			rem_n = (rem_p[k] << 2) | RW'(rad_p[k][RW-1:RW-2]);
			trial = {root_p[k], 2'b01};
			take = rem_n >= trial;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_p[k+1] <= 1'b0;
			end else begin
				v_p[k+1] <= v_p[k];
			end
		end
		always_ff @(posedge clk) begin
			rem_p[k+1] <= take ? rem_n - trial : rem_n;
			root_p[k+1] <= {root_p[k][SQ-2:0], take};
			rad_p[k+1] <= rad_p[k] << 2;
			n_p[k+1] <= n_p[k];
		end
	end

	// Division m*2^F + L/2 over L, three lanes, one quotient bit per stage.
	localparam int DW = 33 + FRAC_BITS + 1;
	logic [DW-1:0] dn [3][QB+1];
	logic [DW-1:0] dr [3][QB+1];
	logic [QB-1:0] dq [3][QB+1];
	logic [SQ-1:0] dl [QB+1];
	nrm_t dnrm [QB+1];
	logic dv [QB+1];

	always_comb begin
		dl[0] = root_p[SQ];
		dnrm[0] = n_p[SQ];
		dv[0] = v_p[SQ];
		dn[0][0] = (DW'(n_p[SQ].mx) << FRAC_BITS) + DW'(root_p[SQ] >> 1);
		dn[1][0] = (DW'(n_p[SQ].my) << FRAC_BITS) + DW'(root_p[SQ] >> 1);
		dn[2][0] = (DW'(n_p[SQ].mz) << FRAC_BITS) + DW'(root_p[SQ] >> 1);
		for (int l = 0; l < 3; l++) begin
			dr[l][0] = DW'(dn[l][0] >> QB);
			dq[l][0] = '0;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv[k+1] <= 1'b0;
			end else begin
				dv[k+1] <= dv[k];
			end
		end
		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [DW:0] rn;
			logic tk;
			always_comb begin
				rn = {dr[l][k], 1'b0};
				// Bring down the next dividend bit, top first.
				rn[0] = dn[l][k][QB-1-k];
				tk = rn >= (DW+1)'(dl[k]);
			end
			always_ff @(posedge clk) begin
				dr[l][k+1] <= tk ? DW'(rn - (DW+1)'(dl[k])) : DW'(rn);
				dq[l][k+1] <= {dq[l][k][QB-2:0], tk};
				dn[l][k+1] <= dn[l][k];
			end
		end
		always_ff @(posedge clk) begin
			dl[k+1] <= dl[k];
			dnrm[k+1] <= dnrm[k];
		end
	end

	// The high dividend bits always give a zero quotient bit, so only the
	// low QB bits need stages: the leading part seeds the remainder.
	// That holds because the quotient is at most 2^F + 1 < 2^QB.

	always_comb begin
		out_valid = dv[QB];
		out_zero = dnrm[QB].zero;
		out_vec.x = dnrm[QB].zero ? '0 :
			(dnrm[QB].nx ? -comp_t'(dq[0][QB]) : comp_t'(dq[0][QB]));
		out_vec.y = dnrm[QB].zero ? '0 :
			(dnrm[QB].ny ? -comp_t'(dq[1][QB]) : comp_t'(dq[1][QB]));
		out_vec.z = dnrm[QB].zero ? '0 :
			(dnrm[QB].nz ? -comp_t'(dq[2][QB]) : comp_t'(dq[2][QB]));
	end
endmodule

### hw/rtl/look_at_view_matrix.sv
// Top level of the look-at view matrix block.
// It depends on lavm_pkg and lavm_norm.
//
// Usage: present pos, dir and upv with start high while busy is low; the word
// is taken at that edge. The block normalizes the direction, forms the right
// and true-up vectors through two cross products and two more normalize
// units, then emits four row words on consecutive cycles, each marked by
// strobe: rows 0, 1, 2 with the basis vector and its saturated translation,
// then row 3 (0,0,0,1) with last_row set. degenerate marks every row of an
// input whose normalization met a zero vector.
// The gap counter raises busy after an accept and holds it while it counts
// down, so accepted words are spaced to fit the four-row output port; the
// pipeline takes new words before earlier ones have left it.
// Path: an input register, three chained normalize units of FRAC_BITS + 39
// stages each, two cross product stages after each of the first two units,
// three dot product stages after the last and one register into the row
// sequencer.
// Reset clears all valid bits and the sequencer; no words are in flight.
// The receiver cannot stall; the output side never waits.
module look_at_view_matrix #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input lavm_pkg::comp_t pos_x,
	input lavm_pkg::comp_t pos_y,
	input lavm_pkg::comp_t pos_z,
	input lavm_pkg::comp_t dir_x,
	input lavm_pkg::comp_t dir_y,
	input lavm_pkg::comp_t dir_z,
	input lavm_pkg::comp_t upv_x,
	input lavm_pkg::comp_t upv_y,
	input lavm_pkg::comp_t upv_z,
	output logic strobe,
	output lavm_pkg::comp_t elem0,
	output lavm_pkg::comp_t elem1,
	output lavm_pkg::comp_t elem2,
	output lavm_pkg::comp_t elem3,
	output logic [1:0] row_number,
	output logic last_row,
	output logic degenerate
);
	import lavm_pkg::*;

	// Latency of one normalize unit: three entry stages, the square root and the divide.
	localparam int NL = 3 + 34 + FRAC_BITS + 2;

	logic [1:0] gap_q;
	logic acc;
	assign acc = start && !busy;
	assign busy = gap_q != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= 2'd0;
		end else if (acc) begin
			gap_q <= 2'd3;
		end else if (gap_q != 2'd0) begin
			gap_q <= gap_q - 2'd1;
		end
	end

	// Input register.
	vec3_t p_s1, u_s1;
	logic v_s1;
	logic signed [63:0] dx_s1, dy_s1, dz_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end
	always_ff @(posedge clk) begin
		p_s1 <= '{pos_x, pos_y, pos_z};
		u_s1 <= '{upv_x, upv_y, upv_z};
		dx_s1 <= 64'(dir_x);
		dy_s1 <= 64'(dir_y);
		dz_s1 <= 64'(dir_z);
	end

	// Forward normalize; position and up ride alongside in delay lines.
	vec3_t f_v;
	logic f_ok, f_z;
	lavm_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(64)) u_nf (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s1),
		.in_x(dx_s1), .in_y(dy_s1), .in_z(dz_s1),
		.out_valid(f_ok), .out_vec(f_v), .out_zero(f_z)
	);

	vec3_t pd1 [NL+1];
	vec3_t ud1 [NL+1];
	always_comb begin
		pd1[0] = p_s1;
		ud1[0] = u_s1;
	end
	for (genvar k = 0; k < NL; k++) begin : g_d1
		always_ff @(posedge clk) begin
			pd1[k+1] <= pd1[k];
			ud1[k+1] <= ud1[k];
		end
	end

	// Cross product up x f: products registered, then differences.
	function automatic logic signed [63:0] mul(comp_t a, comp_t b);
		return 64'(a) * 64'(b);
	endfunction

	logic signed [63:0] c1a_s1, c1b_s1, c2a_s1, c2b_s1, c3a_s1, c3b_s1;
	logic signed [63:0] cx_s2, cy_s2, cz_s2;
	vec3_t f_c1, f_c2, p_c1, p_c2;
	logic v_c1, v_c2, z_c1, z_c2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c1 <= 1'b0;
			v_c2 <= 1'b0;
		end else begin
			v_c1 <= f_ok;
			v_c2 <= v_c1;
		end
	end
	always_ff @(posedge clk) begin
		c1a_s1 <= mul(ud1[NL].y, f_v.z);
		c1b_s1 <= mul(ud1[NL].z, f_v.y);
		c2a_s1 <= mul(ud1[NL].z, f_v.x);
		c2b_s1 <= mul(ud1[NL].x, f_v.z);
		c3a_s1 <= mul(ud1[NL].x, f_v.y);
		c3b_s1 <= mul(ud1[NL].y, f_v.x);
		f_c1 <= f_v;
		p_c1 <= pd1[NL];
		z_c1 <= f_z;
		cx_s2 <= c1a_s1 - c1b_s1;
		cy_s2 <= c2a_s1 - c2b_s1;
		cz_s2 <= c3a_s1 - c3b_s1;
		f_c2 <= f_c1;
		p_c2 <= p_c1;
		z_c2 <= z_c1;
	end

	vec3_t r_v;
	logic r_ok, r_z;
	lavm_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(64)) u_nr (
		.clk(clk), .arst_n(arst_n), .in_valid(v_c2),
		.in_x(cx_s2), .in_y(cy_s2), .in_z(cz_s2),
		.out_valid(r_ok), .out_vec(r_v), .out_zero(r_z)
	);

	vec3_t pd2 [NL+1];
	vec3_t fd2 [NL+1];
	logic zd2 [NL+1];
	always_comb begin
		pd2[0] = p_c2;
		fd2[0] = f_c2;
		zd2[0] = z_c2;
	end
	for (genvar k = 0; k < NL; k++) begin : g_d2
		always_ff @(posedge clk) begin
			pd2[k+1] <= pd2[k];
			fd2[k+1] <= fd2[k];
			zd2[k+1] <= zd2[k];
		end
	end

	// Cross product f x r.
	logic signed [63:0] e1a_s1, e1b_s1, e2a_s1, e2b_s1, e3a_s1, e3b_s1;
	logic signed [63:0] ex_s2, ey_s2, ez_s2;
	vec3_t f_e1, f_e2, p_e1, p_e2, r_e1, r_e2;
	logic v_e1, v_e2, z_e1, z_e2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_e1 <= 1'b0;
			v_e2 <= 1'b0;
		end else begin
			v_e1 <= r_ok;
			v_e2 <= v_e1;
		end
	end
	always_ff @(posedge clk) begin
		e1a_s1 <= mul(fd2[NL].y, r_v.z);
		e1b_s1 <= mul(fd2[NL].z, r_v.y);
		e2a_s1 <= mul(fd2[NL].z, r_v.x);
		e2b_s1 <= mul(fd2[NL].x, r_v.z);
		e3a_s1 <= mul(fd2[NL].x, r_v.y);
		e3b_s1 <= mul(fd2[NL].y, r_v.x);
		f_e1 <= fd2[NL];
		p_e1 <= pd2[NL];
		r_e1 <= r_v;
		z_e1 <= zd2[NL] | r_z;
		ex_s2 <= e1a_s1 - e1b_s1;
		ey_s2 <= e2a_s1 - e2b_s1;
		ez_s2 <= e3a_s1 - e3b_s1;
		f_e2 <= f_e1;
		p_e2 <= p_e1;
		r_e2 <= r_e1;
		z_e2 <= z_e1;
	end

	vec3_t t_v;
	logic t_ok, t_z;
	lavm_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(64)) u_nt (
		.clk(clk), .arst_n(arst_n), .in_valid(v_e2),
		.in_x(ex_s2), .in_y(ey_s2), .in_z(ez_s2),
		.out_valid(t_ok), .out_vec(t_v), .out_zero(t_z)
	);

	vec3_t pd3 [NL+1];
	vec3_t fd3 [NL+1];
	vec3_t rd3 [NL+1];
	logic zd3 [NL+1];
	always_comb begin
		pd3[0] = p_e2;
		fd3[0] = f_e2;
		rd3[0] = r_e2;
		zd3[0] = z_e2;
	end
	for (genvar k = 0; k < NL; k++) begin : g_d3
		always_ff @(posedge clk) begin
			pd3[k+1] <= pd3[k];
			fd3[k+1] <= fd3[k];
			rd3[k+1] <= rd3[k];
			zd3[k+1] <= zd3[k];
		end
	end

	// Dot products: nine products registered, then sums, then negation, rounding and saturation.
	logic signed [63:0] pr_s1 [3][3];
	vec3_t bs [3];
	vec3_t b_t1 [3];
	logic v_t1, v_t2, v_t3, dg_t1, dg_t2, dg_t3;
	always_comb begin
		bs[0] = rd3[NL];
		bs[1] = t_v;
		bs[2] = fd3[NL];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_t1 <= 1'b0;
			v_t2 <= 1'b0;
			v_t3 <= 1'b0;
		end else begin
			v_t1 <= t_ok;
			v_t2 <= v_t1;
			v_t3 <= v_t2;
		end
	end

	logic signed [65:0] d_t2 [3];
	vec3_t b_t2 [3];
	vec3_t b_t3 [3];
	comp_t tr_t3 [3];
	for (genvar r = 0; r < 3; r++) begin : g_dot
		logic [65:0] mg, rd;
		logic signed [66:0] nv;
		always_ff @(posedge clk) begin
			pr_s1[r][0] <= mul(bs[r].x, pd3[NL].x);
			pr_s1[r][1] <= mul(bs[r].y, pd3[NL].y);
			pr_s1[r][2] <= mul(bs[r].z, pd3[NL].z);
			b_t1[r] <= bs[r];
			d_t2[r] <= 66'(pr_s1[r][0]) + 66'(pr_s1[r][1]) + 66'(pr_s1[r][2]);
			b_t2[r] <= b_t1[r];
			b_t3[r] <= b_t2[r];
			tr_t3[r] <= (nv > 67'sd2147483647) ? comp_t'(32'h7fffffff) :
				(nv < -67'sd2147483648) ? comp_t'(32'h80000000) : comp_t'(nv);
		end
		always_comb begin
			mg = d_t2[r][65] ? 66'(-d_t2[r]) : 66'(d_t2[r]);
			rd = (mg + (66'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
			nv = d_t2[r][65] ? 67'(rd) : -67'(rd);
		end
	end
	always_ff @(posedge clk) begin
		dg_t1 <= zd3[NL] | t_z;
		dg_t2 <= dg_t1;
		dg_t3 <= dg_t2;
	end

	// Row sequencer: loads a finished item and plays four rows.
	vec3_t rows_q [3];
	comp_t trs_q [3];
	logic dg_q;
	logic [1:0] row_q;
	logic run_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			row_q <= 2'd0;
		end else if (v_t3) begin
			run_q <= 1'b1;
			row_q <= 2'd0;
		end else if (run_q) begin
			row_q <= row_q + 2'd1;
			run_q <= row_q != 2'd3;
		end
	end
	always_ff @(posedge clk) begin
		if (v_t3) begin
			rows_q <= b_t3;
			trs_q <= tr_t3;
			dg_q <= dg_t3;
		end
	end

	always_comb begin
		strobe = run_q;
		row_number = row_q;
		last_row = row_q == 2'd3;
		degenerate = dg_q;
		if (row_q == 2'd3) begin
			elem0 = '0;
			elem1 = '0;
			elem2 = '0;
			elem3 = comp_t'(1) <<< FRAC_BITS;
		end else begin
			elem0 = rows_q[row_q].x;
			elem1 = rows_q[row_q].y;
			elem2 = rows_q[row_q].z;
			elem3 = trs_q[row_q];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) acc |=> busy)
		else $error("busy did not rise after an accept");
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_row) |=> strobe)
		else $error("row run broke off early");
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_row) |-> row_number == 2'd3)
		else $error("last_row on a wrong row");
endmodule

### test/look_at_view_matrix_tb.sv
// Self-checking testbench for the look-at view matrix block.
// It depends on lavm_pkg and the look_at_view_matrix top level.
// A scoreboard class predicts the four matrix rows of every accepted camera word.
`timescale 1ns / 100ps

module look_at_view_matrix_tb;
	import lavm_pkg::*;

	localparam int FracBits = 16;
	localparam int QuietLimit = 5000;
	localparam int TailCycles = 400;
	localparam int RandomWords = 104;

	typedef longint signed wide3_t [3];

	typedef struct {
		vec3_t pos;
		vec3_t dir;
		vec3_t upv;
	} camera_t;

	typedef struct {
		comp_t e0;
		comp_t e1;
		comp_t e2;
		comp_t e3;
		logic [1:0] row;
		logic last;
		logic degen;
	} row_word_t;

	// The scoreboard keeps the rows that the block still owes, oldest first.
	class view_matrix_book;
		row_word_t owed_rows[$];
		int cameras_seen;
		int degenerate_seen;

		function automatic longint unsigned floor_sqrt(longint unsigned x);
			longint unsigned res = 0;
			longint unsigned b = 64'd1 << 62;
			while (b > x)
				b >>= 2;
			while (b != 0) begin
				if (x >= res + b) begin
					x -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		// Scales the vector into [2^30, 2^31] before the square root, as the block does.
		function automatic bit to_unit(input wide3_t c, output wide3_t u);
			longint unsigned m[3];
			bit neg[3];
			longint unsigned mx = 0;
			longint unsigned len;
			longint unsigned q;
			for (int i = 0; i < 3; i++) begin
				neg[i] = c[i] < 0;
				m[i] = neg[i] ? -c[i] : c[i];
				if (m[i] > mx)
					mx = m[i];
			end
			if (mx == 0) begin
				u = '{0, 0, 0};
				return 0;
			end
			while (mx > (64'd1 << 31)) begin
				for (int i = 0; i < 3; i++)
					m[i] >>= 1;
				mx >>= 1;
			end
			while (mx < (64'd1 << 30)) begin
				for (int i = 0; i < 3; i++)
					m[i] <<= 1;
				mx <<= 1;
			end
			len = floor_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
			for (int i = 0; i < 3; i++) begin
				q = ((m[i] << FracBits) + len / 2) / len;
				u[i] = neg[i] ? -longint'(q) : longint'(q);
			end
			return 1;
		endfunction

		function automatic wide3_t cross_prod(wide3_t a, wide3_t b);
			wide3_t r;
			r[0] = a[1] * b[2] - a[2] * b[1];
			r[1] = a[2] * b[0] - a[0] * b[2];
			r[2] = a[0] * b[1] - a[1] * b[0];
			return r;
		endfunction

		// Negated dot product, rounded half away from zero and saturated to 32 bits.
		function automatic comp_t shift_term(wide3_t b, wide3_t p);
			longint signed d;
			longint unsigned mag;
			longint signed r;
			d = b[0] * p[0] + b[1] * p[1] + b[2] * p[2];
			mag = d < 0 ? -d : d;
			mag = (mag + (64'd1 << (FracBits - 1))) >> FracBits;
			r = d < 0 ? longint'(mag) : -longint'(mag);
			if (r > 64'sd2147483647)
				r = 64'sd2147483647;
			if (r < -64'sd2147483648)
				r = -64'sd2147483648;
			return comp_t'(r);
		endfunction

		function automatic void note_camera(camera_t cam);
			wide3_t p, d, up, f, rt, tu, tmp;
			wide3_t basis[3];
			bit ok;
			row_word_t w;
			p = '{longint'(cam.pos.x), longint'(cam.pos.y), longint'(cam.pos.z)};
			d = '{longint'(cam.dir.x), longint'(cam.dir.y), longint'(cam.dir.z)};
			up = '{longint'(cam.upv.x), longint'(cam.upv.y), longint'(cam.upv.z)};
			ok = to_unit(d, f);
			tmp = cross_prod(up, f);
			ok &= to_unit(tmp, rt);
			tmp = cross_prod(f, rt);
			ok &= to_unit(tmp, tu);
			basis[0] = rt;
			basis[1] = tu;
			basis[2] = f;
			for (int k = 0; k < RowCount; k++) begin
				if (k < 3) begin
					w.e0 = comp_t'(basis[k][0]);
					w.e1 = comp_t'(basis[k][1]);
					w.e2 = comp_t'(basis[k][2]);
					w.e3 = shift_term(basis[k], p);
				end else begin
					w.e0 = '0;
					w.e1 = '0;
					w.e2 = '0;
					w.e3 = comp_t'(1) <<< FracBits;
				end
				w.row = k[1:0];
				w.last = (k == 3);
				w.degen = !ok;
				owed_rows.push_back(w);
			end
			cameras_seen++;
			if (!ok)
				degenerate_seen++;
		endfunction

		// Returns an empty string when the row matches the oldest owed row.
		function automatic string check_row(row_word_t got);
			row_word_t exp;
			if (owed_rows.size() == 0)
				return $sformatf("row %0d arrived with nothing owed", got.row);
			exp = owed_rows.pop_front();
			// Unknown bits on any port count as a mismatch.
			if (got.e0 !== exp.e0 || got.e1 !== exp.e1 || got.e2 !== exp.e2 ||
				got.e3 !== exp.e3 || got.row !== exp.row || got.last !== exp.last ||
				got.degen !== exp.degen)
				return $sformatf({"row %0d: got %h %h %h %h r%0d l%0d d%0d, ",
					"want %h %h %h %h r%0d l%0d d%0d"},
					exp.row, got.e0, got.e1, got.e2, got.e3, got.row, got.last, got.degen,
					exp.e0, exp.e1, exp.e2, exp.e3, exp.row, exp.last, exp.degen);
			return "";
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	comp_t pos_x = '0, pos_y = '0, pos_z = '0;
	comp_t dir_x = '0, dir_y = '0, dir_z = '0;
	comp_t upv_x = '0, upv_y = '0, upv_z = '0;
	logic strobe;
	comp_t elem0, elem1, elem2, elem3;
	logic [1:0] row_number;
	logic last_row;
	logic degenerate;

	view_matrix_book book = new();
	int mismatches = 0;
	int rows_checked = 0;
	int quiet_cycles = 0;
	int burst_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	look_at_view_matrix #(.FRAC_BITS(FracBits)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.dir_x(dir_x),
		.dir_y(dir_y),
		.dir_z(dir_z),
		.upv_x(upv_x),
		.upv_y(upv_y),
		.upv_z(upv_z),
		.strobe(strobe),
		.elem0(elem0),
		.elem1(elem1),
		.elem2(elem2),
		.elem3(elem3),
		.row_number(row_number),
		.last_row(last_row),
		.degenerate(degenerate)
	);

	task automatic report(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Every row word is checked at the edge that ends its strobe cycle; the
	// receiver has no way to stall, so nothing is held off here.
	always @(posedge clk) begin
		string msg;
		if (arst_n && strobe === 1'b1) begin
			msg = book.check_row('{elem0, elem1, elem2, elem3, row_number, last_row, degenerate});
			rows_checked++;
			if (msg != "")
				report(msg);
		end
	end

	// The watchdog restarts on every accepted camera word and every row word.
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || strobe === 1'b1)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("watchdog: no progress for %0d cycles", QuietLimit);
			$display("look_at_view_matrix verification failed");
			$finish;
		end
	end

	// Sends one camera word. The sender works in bursts: between bursts start
	// drops for a random gap, inside a burst words go back to back.
	task automatic send_camera(camera_t cam);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) :
				$urandom_range(1, 6);
		end
		burst_left--;
		start <= 1'b1;
		pos_x <= cam.pos.x;
		pos_y <= cam.pos.y;
		pos_z <= cam.pos.z;
		dir_x <= cam.dir.x;
		dir_y <= cam.dir.y;
		dir_z <= cam.dir.z;
		upv_x <= cam.upv.x;
		upv_y <= cam.upv.y;
		upv_z <= cam.upv.z;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		book.note_camera(cam);
	endtask

	function automatic comp_t any_comp(int unsigned kind);
		comp_t v;
		case (kind)
			0: v = comp_t'($urandom);
			1: v = comp_t'($urandom_range(0, 1 << 20)) * ($urandom_range(0, 1) ? 1 : -1);
			2: v = comp_t'($urandom_range(0, 1 << 12)) * ($urandom_range(0, 1) ? 1 : -1);
			default: begin
				case ($urandom_range(0, 4))
					0: v = 32'sh7fffffff;
					1: v = 32'sh80000000;
					2: v = '0;
					3: v = 32'sh00010000;
					default: v = -32'sh00000001;
				endcase
			end
		endcase
		return v;
	endfunction

	function automatic vec3_t any_vec(int unsigned kind);
		return '{any_comp(kind), any_comp(kind), any_comp(kind)};
	endfunction

	function automatic camera_t random_camera();
		camera_t cam;
		int unsigned k;
		k = $urandom_range(0, 9);
		cam.pos = any_vec(k < 4 ? 0 : (k < 7 ? 1 : (k < 9 ? 2 : 3)));
		cam.dir = any_vec($urandom_range(0, 3));
		case ($urandom_range(0, 9))
			0: cam.upv = '{0, 0, 0};
			1: cam.upv = cam.dir;
			2: cam.upv = '{-cam.dir.x, -cam.dir.y, -cam.dir.z};
			default: cam.upv = any_vec($urandom_range(0, 3));
		endcase
		if ($urandom_range(0, 19) == 0)
			cam.dir = '{0, 0, 0};
		return cam;
	endfunction

	localparam comp_t One = 32'sh00010000;
	localparam comp_t MaxC = 32'sh7fffffff;
	localparam comp_t MinC = 32'sh80000000;

	initial begin
		camera_t directed[$];
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Plain axis-aligned camera, then directions along x and along -y.
		directed.push_back('{'{One, 2 * One, 3 * One}, '{0, 0, One}, '{0, One, 0}});
		directed.push_back('{'{0, 0, 0}, '{One, 0, 0}, '{0, One, 0}});
		directed.push_back('{'{-One, 0, 0}, '{0, -One, 0}, '{0, 0, One}});
		// A zero direction: all basis rows zero and degenerate on every row.
		directed.push_back('{'{One, One, One}, '{0, 0, 0}, '{0, One, 0}});
		// A zero up hint, then an up hint parallel and antiparallel to the direction.
		directed.push_back('{'{One, One, One}, '{0, 0, One}, '{0, 0, 0}});
		directed.push_back('{'{One, 0, 0}, '{0, 3 * One, 0}, '{0, One, 0}});
		directed.push_back('{'{0, One, 0}, '{One, One, One}, '{-2, -2, -2}});
		// Translation saturation in both directions with a diagonal basis.
		directed.push_back('{'{MinC, MinC, MinC}, '{One, One, One}, '{0, One, 0}});
		directed.push_back('{'{MaxC, MaxC, MaxC}, '{One, One, One}, '{0, One, 0}});
		directed.push_back('{'{MaxC, MinC, MaxC}, '{-One, -One, -One}, '{One, 0, 0}});
		// Extreme components in direction and up hint.
		directed.push_back('{'{MaxC, MaxC, MaxC}, '{MaxC, MaxC, MaxC}, '{MinC, MinC, MaxC}});
		directed.push_back('{'{MinC, MinC, MinC}, '{MinC, MinC, MinC}, '{MaxC, MinC, MinC}});
		directed.push_back('{'{MinC, 0, MaxC}, '{MinC, 0, 0}, '{0, MaxC, 0}});
		// Tiny vectors that are scaled up before the square root.
		directed.push_back('{'{1, -1, 1}, '{1, 0, 0}, '{0, 1, 1}});
		directed.push_back('{'{-1, -1, -1}, '{-1, 1, -1}, '{1, 1, -1}});
		directed.push_back('{'{One, One, One}, '{1, 2, 3}, '{-3, 2, 1}});
		foreach (directed[i])
			send_camera(directed[i]);

		for (int n = 0; n < RandomWords; n++)
			send_camera(random_camera());
		start <= 1'b0;

		while (book.owed_rows.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);

		$display("Sent %0d camera words (%0d degenerate), checked %0d matrix rows.",
			book.cameras_seen, book.degenerate_seen, rows_checked);
		if (book.owed_rows.size() != 0)
			report($sformatf("%0d rows never arrived", book.owed_rows.size()));
		if (mismatches == 0)
			$display("look_at_view_matrix verification clean");
		else
			$display("look_at_view_matrix verification failed");
		$finish;
	end
endmodule
